// ----- rtl/ttsch_pkg.sv -----
`default_nettype none
package ttsch_pkg;

	localparam int ACT_W  = 3;
	localparam int SLOT_W = 4;
	localparam int TASK_W = 8;
	localparam int TICK_W = 32;
	localparam int PEND_W = 8;
	localparam int STAT_W = 2;

	localparam logic [ACT_W-1:0] ACT_INIT     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ADD      = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_MODIFY   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_TICK     = 3'd4;
	localparam logic [ACT_W-1:0] ACT_DISPATCH = 3'd5;

	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_DUE     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTHING = 2'd3;

	localparam logic [PEND_W-1:0] PEND_MAX = 8'd255;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [SLOT_W-1:0] slot;
		logic [TASK_W-1:0] task_id;
		logic [TICK_W-1:0] period_ticks;
		logic [TICK_W-1:0] delay_ticks;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] result_slot;
		logic [TASK_W-1:0] result_task_id;
		logic [TICK_W-1:0] old_period;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic issue_last;
	} stat_t;

endpackage
`default_nettype wire

// ----- rtl/time_triggered_task_scheduler_top.sv -----
`default_nettype none
// Channel   Handshake            Payload
// input     start, busy          item   (in_item_t)
// result    strobe               result (out_item_t), last marks the final item
//
// An item is taken when start is high and busy is low. Tick and dispatch walk
// every slot (one slot a cycle through the slot RAM read port), add walks the
// slots while it scans for a free slot, every other action does not walk. Dispatch
// gives one result per due slot in slot order, at most one a cycle. Reset clears
// the valid marks at once, no clearing pass. Results are never stalled; the strobe
// holds each one for exactly one cycle.
module time_triggered_task_scheduler_top
	import ttsch_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire in_item_t item,
	output logic          strobe,
	output out_item_t     result
);

	cmd_t  cmd;
	stat_t st;

	ttsch_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.st     (st)
	);

	ttsch_dp #(.SLOTS(SLOTS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.st     (st),
		.strobe (strobe),
		.result (result)
	);

endmodule
`default_nettype wire

// ----- rtl/ttsch_ram.sv -----
`default_nettype none
module ttsch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/ttsch_ctrl.sv -----
`default_nettype none
module ttsch_ctrl
	import ttsch_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	output cmd_t       cmd,
	input  wire stat_t st
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RUN   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_RUN;
			end
			S_RUN: begin
				if (st.issue_last) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign cmd.load   = (state_q == S_IDLE) && start;
	assign cmd.issue  = (state_q == S_RUN);
	assign cmd.finish = (state_q == S_DONE);

endmodule
`default_nettype wire

// ----- rtl/ttsch_dp.sv -----
`default_nettype none
module ttsch_dp
	import ttsch_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t item,
	input  wire cmd_t     cmd,
	output stat_t         st,
	output logic          strobe,
	output out_item_t     result
);

	localparam int AW = $clog2(SLOTS);
	localparam int XW = SLOT_W + AW;

	logic [ACT_W-1:0]  op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TASK_W-1:0] task_q;
	logic [TICK_W-1:0] period_q;
	logic [TICK_W-1:0] delay_q;

	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    idx_s1;
	logic             vld_s1;
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] pok_q;

	logic             hold_full_q;
	out_item_t        hold_q;
	out_item_t        out_q;
	logic             strobe_q;

	logic [XW-1:0] slot_wide;
	logic          in_rng;
	logic [AW-1:0] slot_addr;
	logic          idx_last;
	logic          is_walk;
	logic          is_add;
	logic          is_mod;
	logic          free_here;
	logic          add_wr;

	logic [TASK_W-1:0] task_rd;
	logic [TICK_W-1:0] period_rd;
	logic [TICK_W-1:0] delay_rd;
	logic [PEND_W-1:0] pend_rd;
	logic [TICK_W-1:0] per_eff;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;

	logic              tick_wr;
	logic              due;
	logic              drain_del;
	logic              per_we;
	logic              dly_we;
	logic              pend_we;
	logic [TICK_W-1:0] dly_wd;
	logic [PEND_W-1:0] pend_wd;
	logic [TICK_W-1:0] dly_new;
	logic [PEND_W-1:0] pend_new;

	logic      cand_vld;
	out_item_t cand;
	out_item_t fin;

	assign slot_wide = XW'(slot_q);
	assign in_rng    = slot_wide < XW'(SLOTS);
	assign slot_addr = slot_wide[AW-1:0];
	assign idx_last  = (idx_q == AW'(SLOTS - 1));
	assign is_walk   = (op_q == ACT_TICK) || (op_q == ACT_DISPATCH);
	assign is_add    = (op_q == ACT_ADD);
	assign is_mod    = (op_q == ACT_MODIFY);
	assign free_here = !valid_q[idx_q];
	assign add_wr    = cmd.issue && is_add && free_here;

	assign st.issue_last = !(is_walk || is_add) || idx_last || (is_add && free_here);

	assign raddr   = is_mod ? slot_addr : idx_q;
	assign waddr   = add_wr ? idx_q : idx_s1;
	assign per_eff = pok_q[idx_s1] ? period_rd : '0;

	assign tick_wr   = vld_s1 && (op_q == ACT_TICK) && valid_q[idx_s1];
	assign due       = vld_s1 && (op_q == ACT_DISPATCH) && valid_q[idx_s1] && (pend_rd != '0);
	assign drain_del = due && (pend_rd == PEND_W'(1)) && (per_eff == '0);

	always_comb begin
		dly_new  = delay_rd - TICK_W'(1);
		pend_new = pend_rd;
		if (op_q == ACT_DISPATCH) begin
			pend_new = pend_rd - PEND_W'(1);
		end else if (delay_rd == '0) begin
			if (pend_rd != PEND_MAX) pend_new = pend_rd + PEND_W'(1);
			dly_new = (per_eff != '0) ? per_eff : delay_rd;
		end
	end

	assign per_we  = add_wr || (vld_s1 && is_mod && in_rng);
	assign dly_we  = add_wr || tick_wr;
	assign pend_we = add_wr || tick_wr || due;
	assign dly_wd  = add_wr ? delay_q : dly_new;
	assign pend_wd = add_wr ? '0 : pend_new;

	ttsch_ram #(.WIDTH(TASK_W), .DEPTH(SLOTS)) u_task (
		.clk(clk), .we(add_wr), .waddr(idx_q), .wdata(task_q),
		.raddr(raddr), .rdata(task_rd)
	);

	ttsch_ram #(.WIDTH(TICK_W), .DEPTH(SLOTS)) u_period (
		.clk(clk), .we(per_we), .waddr(waddr), .wdata(period_q),
		.raddr(raddr), .rdata(period_rd)
	);

	ttsch_ram #(.WIDTH(TICK_W), .DEPTH(SLOTS)) u_delay (
		.clk(clk), .we(dly_we), .waddr(waddr), .wdata(dly_wd),
		.raddr(raddr), .rdata(delay_rd)
	);

	ttsch_ram #(.WIDTH(PEND_W), .DEPTH(SLOTS)) u_pend (
		.clk(clk), .we(pend_we), .waddr(waddr), .wdata(pend_wd),
		.raddr(raddr), .rdata(pend_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= item.action;
			slot_q   <= item.slot;
			task_q   <= item.task_id;
			period_q <= item.period_ticks;
			delay_q  <= item.delay_ticks;
		end
		if (cmd.issue) begin
			idx_s1 <= is_mod ? slot_addr : idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			vld_s1  <= 1'b0;
			valid_q <= '0;
			pok_q   <= '0;
		end else begin
			vld_s1 <= cmd.issue && (is_walk || is_mod);
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.issue && (op_q == ACT_INIT)) begin
				valid_q <= '0;
				pok_q   <= '0;
			end
			if (cmd.issue && (op_q == ACT_DELETE) && in_rng) begin
				valid_q[slot_addr] <= 1'b0;
				pok_q[slot_addr]   <= 1'b0;
			end
			if (add_wr) begin
				valid_q[idx_q] <= 1'b1;
				pok_q[idx_q]   <= 1'b1;
			end
			if (vld_s1 && is_mod && in_rng) begin
				pok_q[idx_s1] <= 1'b1;
			end
			if (drain_del) begin
				valid_q[idx_s1] <= 1'b0;
				pok_q[idx_s1]   <= 1'b0;
			end
		end
	end

	always_comb begin
		cand_vld = 1'b0;
		cand     = '0;
		if (cmd.issue && is_add && (free_here || idx_last)) begin
			cand_vld           = 1'b1;
			cand.status        = free_here ? ST_DONE : ST_FULL;
			cand.result_slot   = free_here ? SLOT_W'(idx_q) : '0;
		end
		if (due) begin
			cand_vld            = 1'b1;
			cand.status         = ST_DUE;
			cand.result_slot    = SLOT_W'(idx_s1);
			cand.result_task_id = task_rd;
		end
		if (vld_s1 && is_mod) begin
			cand_vld        = 1'b1;
			cand.status     = ST_DONE;
			cand.old_period = in_rng ? per_eff : '0;
		end
	end

	always_comb begin
		fin      = '0;
		if (hold_full_q) begin
			fin = hold_q;
		end else if (op_q == ACT_DISPATCH) begin
			fin.status = ST_NOTHING;
		end else begin
			fin.status = ST_DONE;
		end
		fin.last = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cand_vld) begin
			hold_q <= cand;
			out_q  <= hold_q;
		end else if (cmd.finish) begin
			out_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_full_q <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= (cand_vld && hold_full_q) || (!cand_vld && cmd.finish);
			if (cmd.load || cmd.finish) begin
				hold_full_q <= 1'b0;
			end else if (cand_vld) begin
				hold_full_q <= 1'b1;
			end
		end
	end

	assign strobe = strobe_q;
	assign result = out_q;

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !vld_s1 && !hold_full_q)
		else $error("stage or hold still full after load");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> strobe_q && out_q.last)
		else $error("finish did not emit a final item");

	a_finish_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !vld_s1 && !cand_vld)
		else $error("finish while work in flight");

	a_early_is_due: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !out_q.last |-> out_q.status == ST_DUE)
		else $error("non-final item that is not a dispatch");

endmodule
`default_nettype wire
